[rtl/sqlsp_pkg.sv]
package sqlsp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int TAG_BITS    = 32;

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef enum logic [2:0] {
        CMD_BEGIN       = 3'd0,
        CMD_COMMIT      = 3'd1,
        CMD_ROLLBACK    = 3'd2,
        CMD_SAVEPOINT   = 3'd3,
        CMD_ROLLBACK_TO = 3'd4,
        CMD_RELEASE     = 3'd5,
        CMD_MARK_FAILED = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_IN_TXN = 2'd1,
        ST_FAILED = 2'd2
    } t_txn_status;

    typedef enum logic [1:0] {
        RK_COMPLETE = 2'd0,
        RK_ERROR    = 2'd1,
        RK_NONE     = 2'd2
    } t_reply_kind;

    typedef enum logic [2:0] {
        CT_BEGIN     = 3'd0,
        CT_COMMIT    = 3'd1,
        CT_ROLLBACK  = 3'd2,
        CT_SAVEPOINT = 3'd3,
        CT_RELEASE   = 3'd4
    } t_complete_tag;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_ALREADY      = 3'd1,
        ERR_FAILED_BLOCK = 3'd2,
        ERR_NO_TXN       = 3'd3,
        ERR_UNKNOWN_SP   = 3'd4,
        ERR_STACK_FULL   = 3'd5
    } t_error_code;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECIDE = 2'd1,
        S_SEARCH = 2'd2,
        S_FINISH = 2'd3
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic search_start;
        logic search_step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_search;
        logic search_hit;
        logic search_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/sqlsp_ctrl.sv]
module sqlsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  sqlsp_pkg::t_dp_stat i_stat,
    output sqlsp_pkg::t_dp_cmd  o_cmd
);
    import sqlsp_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.need_search) begin
                    o_cmd.search_start = 1'b1;
                    n_state            = S_SEARCH;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_stat.search_hit || i_stat.search_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Wait here only while the previous result is still unclaimed.
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/sqlsp_dp.sv]
module sqlsp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         s_axis_tdata,
    input  logic [2:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,
    output logic [1:0]          m_axis_tuser,
    input  sqlsp_pkg::t_dp_cmd  i_cmd,
    output sqlsp_pkg::t_dp_stat o_stat
);
    import sqlsp_pkg::*;

    t_tag          r_mem [STACK_DEPTH];
    t_tag          r_rd_data;
    t_idx          rd_addr;

    t_cmd          r_cmd;
    t_tag          r_tag;
    t_txn_status   r_status;
    t_cnt          r_count;
    t_idx          r_idx;
    logic          r_found;
    t_idx          r_pos;

    logic          r_out_valid;
    t_reply_kind   r_out_kind;
    t_complete_tag r_out_ctag;
    t_error_code   r_out_err;
    t_txn_status   r_out_status;

    t_reply_kind   n_kind;
    t_complete_tag n_ctag;
    t_error_code   n_err;
    t_txn_status   n_status;
    t_cnt          n_count;
    logic          push;
    logic          hit;

    assign hit = (r_rd_data == r_tag);

    assign o_stat.need_search = (r_count != '0) &&
                                (((r_cmd == CMD_ROLLBACK_TO) && (r_status != ST_IDLE)) ||
                                 ((r_cmd == CMD_RELEASE) && (r_status == ST_IN_TXN)));
    assign o_stat.search_hit  = hit;
    assign o_stat.search_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_stat.out_free    = !r_out_valid || m_axis_tready;

    assign rd_addr = i_cmd.search_start ? '0 : (r_idx + IDX_W'(1));

    // Tag store: one write port for pushes, one registered read port for the search.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (i_cmd.finish && push) begin
            r_mem[r_count[IDX_W-1:0]] <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= t_cmd'(s_axis_tuser);
            r_tag   <= TAG_BITS'(s_axis_tdata);
            r_found <= 1'b0;
        end
        if (i_cmd.search_start) begin
            r_idx <= '0;
        end else if (i_cmd.search_step) begin
            if (hit) begin
                r_found <= 1'b1;
                r_pos   <= r_idx;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
        if (i_cmd.finish) begin
            r_out_kind   <= n_kind;
            r_out_ctag   <= n_ctag;
            r_out_err    <= n_err;
            r_out_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_status    <= n_status;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_kind   = RK_NONE;
        n_ctag   = CT_BEGIN;
        n_err    = ERR_NONE;
        n_status = r_status;
        n_count  = r_count;
        push     = 1'b0;
        case (r_cmd)
            CMD_BEGIN: begin
                if (r_status != ST_IDLE) begin
                    n_status = ST_FAILED;
                    n_kind   = RK_ERROR;
                    n_err    = ERR_ALREADY;
                end else begin
                    n_status = ST_IN_TXN;
                    n_kind   = RK_COMPLETE;
                    n_ctag   = CT_BEGIN;
                end
            end
            CMD_COMMIT: begin
                if (r_status == ST_FAILED) begin
                    n_kind = RK_ERROR;
                    n_err  = ERR_FAILED_BLOCK;
                end else begin
                    n_status = ST_IDLE;
                    n_count  = '0;
                    n_kind   = RK_COMPLETE;
                    n_ctag   = CT_COMMIT;
                end
            end
            CMD_ROLLBACK: begin
                n_status = ST_IDLE;
                n_count  = '0;
                n_kind   = RK_COMPLETE;
                n_ctag   = CT_ROLLBACK;
            end
            CMD_SAVEPOINT: begin
                if (r_status != ST_IN_TXN) begin
                    n_kind = RK_ERROR;
                    n_err  = ERR_NO_TXN;
                end else if (r_count >= CNT_W'(STACK_DEPTH)) begin
                    n_kind = RK_ERROR;
                    n_err  = ERR_STACK_FULL;
                end else begin
                    push    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_kind  = RK_COMPLETE;
                    n_ctag  = CT_SAVEPOINT;
                end
            end
            CMD_ROLLBACK_TO: begin
                if (r_status == ST_IDLE) begin
                    n_kind = RK_ERROR;
                    n_err  = ERR_NO_TXN;
                end else if (!r_found) begin
                    n_status = ST_FAILED;
                    n_kind   = RK_ERROR;
                    n_err    = ERR_UNKNOWN_SP;
                end else begin
                    // The matching savepoint itself stays on the stack.
                    n_count  = CNT_W'(r_pos) + CNT_W'(1);
                    n_status = ST_IN_TXN;
                    n_kind   = RK_COMPLETE;
                    n_ctag   = CT_ROLLBACK;
                end
            end
            CMD_RELEASE: begin
                if (r_status != ST_IN_TXN) begin
                    n_kind = RK_ERROR;
                    n_err  = ERR_NO_TXN;
                end else if (!r_found) begin
                    n_status = ST_FAILED;
                    n_kind   = RK_ERROR;
                    n_err    = ERR_UNKNOWN_SP;
                end else begin
                    n_count = CNT_W'(r_pos);
                    n_kind  = RK_COMPLETE;
                    n_ctag  = CT_RELEASE;
                end
            end
            CMD_MARK_FAILED: begin
                n_status = ST_FAILED;
            end
            default: begin
                n_kind = RK_NONE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_status, r_out_err, r_out_ctag};
    assign m_axis_tuser  = r_out_kind;

endmodule

[rtl/sql_transaction_savepoint_tracker.sv]
// Transaction and savepoint tracker for one database session. Each input item
// carries a command in s_axis_tuser and a savepoint tag in s_axis_tdata, and
// produces exactly one result item: the reply kind in m_axis_tuser and the
// completion tag, error code and resulting status in m_axis_tdata. Items are
// processed one at a time. Most commands pass through three steps (accept,
// decode, finish), and their result is written to the output register in the
// finish step. Rollback-to and release add a search step between decode and
// finish, because the oldest matching tag is found by walking the tag
// memory one entry per cycle through its single registered read port. A new
// item is accepted while the previous result still waits to be taken. The
// finish step of that new item then stalls until the earlier result has been
// taken. The tag memory is not cleared after reset; only entries below the
// stack count are ever compared.
module sql_transaction_savepoint_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] savepoint_tag
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] complete_tag, [5:3] error_code, [7:6] status
    output logic [1:0]  m_axis_tuser    // [1:0] reply_kind
);
    import sqlsp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sqlsp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_stat        (dp_stat),
        .o_cmd         (dp_cmd)
    );

    sqlsp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat)
    );

endmodule
